// ----- hw/rtl/lswc_pkg.sv -----
// ----------------------------------------------------------------------------
// lswc_pkg
// Shared types and constants of the leak sensor window classifier.
// ----------------------------------------------------------------------------
package lswc_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int IDX_W        = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   localparam int ADC_W   = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [ADC_W-1:0] HYST_RESET    = 16'd16;
   localparam logic [ADC_W-1:0] ADC_MAX_RESET = 16'd4095;
   localparam logic [ADC_W-1:0] ADC_MIN_RESET = 16'd0;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_RESET  = 2'd1,
      REQ_WRITE  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_BAD_INDEX  = 2'd1,
      STS_BAD_BOUNDS = 2'd2
   } rsp_status_type;

   typedef enum logic [1:0] {
      SNS_NOMINAL = 2'd0,
      SNS_SHORT   = 2'd1,
      SNS_LEAK    = 2'd2,
      SNS_OPEN    = 2'd3
   } sensor_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HYSTERESIS = 2'd0,
      CSR_ADC_MAX    = 2'd1,
      CSR_ADC_MIN    = 2'd2
   } csr_index_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_EXEC = 1'b1
   } ctrl_state_type;

   // One entry of the threshold memory
   typedef struct packed {
      logic [ADC_W-1:0] high_bound;
      logic [ADC_W-1:0] mid_bound;
      logic [ADC_W-1:0] low_bound;
   } bounds_type;

   // Configuration handed to the window unit
   typedef struct packed {
      logic [ADC_W-1:0] hysteresis;
      logic [ADC_W-1:0] adc_max;
      logic [ADC_W-1:0] adc_min;
   } csr_type;

endpackage

// ----- hw/rtl/leak_sensor_window_classifier.sv -----
// ----------------------------------------------------------------------------
// leak_sensor_window_classifier
// Per-sensor window comparator with hysteresis and a global alert.
// ----------------------------------------------------------------------------
// Flow: a request is taken only in IDLE; on accept it is latched and its
//   threshold entry read, then EXEC classifies and writes back, registering
//   the result; a stalled result holds the next request in EXEC.
// Reset: synchronous; all sensors nominal, thresholds read as zero through
//   per-entry valid bits, alert clear, registers at their reset values.
// ----------------------------------------------------------------------------
module leak_sensor_window_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [lswc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lswc_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [3:0]                    req_sensor_index,
   input  logic [15:0]                   req_reading,
   input  logic [15:0]                   req_min_leak,
   input  logic [15:0]                   req_max_leak,
   input  logic [15:0]                   req_max_normal,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [1:0]                    rsp_sensor_state,
   output logic                          rsp_state_changed,
   output logic [15:0]                   rsp_window_low,
   output logic [15:0]                   rsp_window_high,
   output logic                          rsp_alert
);
   import lswc_pkg::*;

   // Configuration registers
   csr_type csr_ff;

   // Control
   ctrl_state_type ctrl_ff, ctrl_in;
   logic           accept;
   logic           exec_fire;

   // Latched request
   req_code_type   rtype_ff;
   logic [3:0]     ridx_ff;
   logic [ADC_W-1:0] rreading_ff;
   bounds_type     rnew_ff;

   // Threshold memory and its valid bits
   bounds_type     bound_mem [SENSOR_COUNT];
   bounds_type     mem_rdata_ff;
   logic [SENSOR_COUNT-1:0] bound_vld_ff;
   logic           rd_vld_ff;
   bounds_type     cur_bounds;
   logic           mem_we;
   logic [IDX_W-1:0] exec_addr;

   // Sensor states and alert
   sensor_state_type sensor_ff [SENSOR_COUNT];
   sensor_state_type sensor_in [SENSOR_COUNT];
   logic           alert_ff, alert_in;

   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_status_type rsp_status_ff, rsp_status_in;
   sensor_state_type rsp_state_ff, rsp_state_in;
   logic           rsp_changed_ff, rsp_changed_in;
   logic [ADC_W-1:0] rsp_wlo_ff, rsp_wlo_in;
   logic [ADC_W-1:0] rsp_whi_ff, rsp_whi_in;

   // Execute-stage values
   logic           in_range;
   sensor_state_type cur_state, class_state;
   logic [ADC_W-1:0] sample;
   logic [ADC_W-1:0] win_lo, win_hi;
   logic           bounds_ok;
   logic           any_alert;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.hysteresis <= HYST_RESET;
         csr_ff.adc_max    <= ADC_MAX_RESET;
         csr_ff.adc_min    <= ADC_MIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HYSTERESIS: csr_ff.hysteresis <= csr_wdata[ADC_W-1:0];
            CSR_ADC_MAX:    csr_ff.adc_max    <= csr_wdata[ADC_W-1:0];
            CSR_ADC_MIN:    csr_ff.adc_min    <= csr_wdata[ADC_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      ctrl_in = ctrl_ff;
      unique case (ctrl_ff)
         CTRL_IDLE: if (req_valid) ctrl_in = CTRL_EXEC;
         CTRL_EXEC: if (exec_fire) ctrl_in = CTRL_IDLE;
         default:   ctrl_in = CTRL_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      exec_fire = 1'b0;
      unique case (ctrl_ff)
         CTRL_IDLE: req_ready = 1'b1;
         CTRL_EXEC: exec_fire = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CTRL_IDLE;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   // Latch the request transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         rtype_ff               <= req_code_type'(req_type);
         ridx_ff                <= req_sensor_index;
         rreading_ff            <= req_reading;
         rnew_ff.low_bound      <= req_min_leak;
         rnew_ff.mid_bound      <= req_max_leak;
         rnew_ff.high_bound     <= req_max_normal;
      end
   end

   // Read the threshold entry on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rdata_ff <= bound_mem[req_sensor_index[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (accept) begin
         rd_vld_ff <= bound_vld_ff[req_sensor_index[IDX_W-1:0]];
      end
   end

   // Write back a validated threshold entry
   assign exec_addr = ridx_ff[IDX_W-1:0];
   assign mem_we    = exec_fire && in_range && (rtype_ff == REQ_WRITE) && bounds_ok;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bound_mem[exec_addr] <= rnew_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_vld_ff <= '0;
      end else if (mem_we) begin
         bound_vld_ff[exec_addr] <= 1'b1;
      end
   end

   // Entries never written read as zero
   assign cur_bounds = rd_vld_ff ? mem_rdata_ff : '0;

   // Classify the sample
   assign in_range  = {1'b0, ridx_ff} < 5'(SENSOR_COUNT);
   assign cur_state = sensor_ff[exec_addr];
   assign sample    = ADC_W'(rreading_ff[SAMPLE_WIDTH-1:0]);

   always_comb begin
      if (sample < cur_bounds.low_bound) begin
         class_state = SNS_SHORT;
      end else if (sample < cur_bounds.mid_bound) begin
         class_state = SNS_LEAK;
      end else if (sample < cur_bounds.high_bound) begin
         class_state = SNS_NOMINAL;
      end else begin
         class_state = SNS_OPEN;
      end
   end

   lswc_window u_window (
      .sensor_state (class_state),
      .bounds       (cur_bounds),
      .new_bounds   (rnew_ff),
      .csr          (csr_ff),
      .window_low   (win_lo),
      .window_high  (win_hi),
      .bounds_ok    (bounds_ok)
   );

   // Update sensor states
   always_comb begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         sensor_in[i] = sensor_ff[i];
      end
      if (in_range) begin
         case (rtype_ff)
            REQ_SAMPLE: sensor_in[exec_addr] = class_state;
            REQ_RESET:  sensor_in[exec_addr] = SNS_NOMINAL;
            REQ_WRITE:  if (bounds_ok) sensor_in[exec_addr] = SNS_NOMINAL;
            default: ;
         endcase
      end
   end

   always_comb begin
      any_alert = 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         any_alert = any_alert | (sensor_in[i] != SNS_NOMINAL);
      end
   end

   // Refresh the alert on sample and reset requests only
   assign alert_in = (in_range && (rtype_ff == REQ_SAMPLE || rtype_ff == REQ_RESET))
                     ? any_alert : alert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            sensor_ff[i] <= SNS_NOMINAL;
         end
         alert_ff <= 1'b0;
      end else if (exec_fire) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            sensor_ff[i] <= sensor_in[i];
         end
         alert_ff <= alert_in;
      end
   end

   // Build the result
   always_comb begin
      rsp_status_in  = STS_OK;
      rsp_state_in   = SNS_NOMINAL;
      rsp_changed_in = 1'b0;
      rsp_wlo_in     = '0;
      rsp_whi_in     = '0;
      if (rtype_ff == REQ_NONE) begin
         rsp_status_in = STS_OK;
      end else if (!in_range) begin
         rsp_status_in = STS_BAD_INDEX;
      end else begin
         case (rtype_ff)
            REQ_SAMPLE: begin
               rsp_state_in   = class_state;
               rsp_changed_in = class_state != cur_state;
               rsp_wlo_in     = win_lo;
               rsp_whi_in     = win_hi;
            end
            REQ_WRITE: begin
               if (bounds_ok) begin
                  rsp_wlo_in = rnew_ff.mid_bound;
                  rsp_whi_in = rnew_ff.high_bound;
               end else begin
                  rsp_status_in = STS_BAD_BOUNDS;
                  rsp_state_in  = cur_state;
               end
            end
            default: ;
         endcase
      end
   end

   // Hold the result until the response transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_state_ff   <= rsp_state_in;
         rsp_changed_ff <= rsp_changed_in;
         rsp_wlo_ff     <= rsp_wlo_in;
         rsp_whi_ff     <= rsp_whi_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_sensor_state  = rsp_state_ff;
   assign rsp_state_changed = rsp_changed_ff;
   assign rsp_window_low    = rsp_wlo_ff;
   assign rsp_window_high   = rsp_whi_ff;
   assign rsp_alert         = alert_ff;

endmodule

// ----- hw/rtl/lswc_window.sv -----
// ----------------------------------------------------------------------------
// lswc_window
// Hysteresis re-arm window for a sensor state, and threshold validity check.
// ----------------------------------------------------------------------------
module lswc_window (
   input  lswc_pkg::sensor_state_type sensor_state,
   input  lswc_pkg::bounds_type       bounds,
   input  lswc_pkg::bounds_type       new_bounds,
   input  lswc_pkg::csr_type          csr,
   output logic [15:0]                window_low,
   output logic [15:0]                window_high,
   output logic                       bounds_ok
);
   import lswc_pkg::*;

   logic [ADC_W:0]   l, m, n, h, amax;
   logic [ADC_W:0]   l_plus_h, m_plus_h, n_plus_h;
   logic [ADC_W:0]   l_minus_h, m_minus_h, n_minus_h, amax_minus_n;
   logic [ADC_W:0]   nl, nm, nn;
   logic [ADC_W+1:0] gap, gap_lm, gap_mn;

   // Widen operands by one bit so sums never wrap
   assign l    = {1'b0, bounds.low_bound};
   assign m    = {1'b0, bounds.mid_bound};
   assign n    = {1'b0, bounds.high_bound};
   assign h    = {1'b0, csr.hysteresis};
   assign amax = {1'b0, csr.adc_max};

   assign l_plus_h     = l + h;
   assign m_plus_h     = m + h;
   assign n_plus_h     = n + h;
   assign l_minus_h    = l - h;
   assign m_minus_h    = m - h;
   assign n_minus_h    = n - h;
   assign amax_minus_n = amax - n;

   // Select window bounds by state
   always_comb begin
      case (sensor_state)
         SNS_SHORT: begin
            window_low  = csr.adc_min;
            window_high = (l_plus_h <= m) ? l_plus_h[ADC_W-1:0] : m[ADC_W-1:0];
         end
         SNS_LEAK: begin
            window_low  = (l >= h) ? l_minus_h[ADC_W-1:0] : csr.adc_min;
            window_high = (m_plus_h <= n) ? m_plus_h[ADC_W-1:0] : n[ADC_W-1:0];
         end
         SNS_NOMINAL: begin
            window_low  = (m >= h && m_minus_h >= l) ? m_minus_h[ADC_W-1:0]
                                                     : l[ADC_W-1:0];
            window_high = (amax >= n && amax_minus_n >= h) ? n_plus_h[ADC_W-1:0]
                                                           : csr.adc_max;
         end
         default: begin
            window_low  = (n >= h && n_minus_h >= m) ? n_minus_h[ADC_W-1:0]
                                                     : m[ADC_W-1:0];
            window_high = csr.adc_max;
         end
      endcase
   end

   // Check ordering, margins and gaps of a threshold write
   assign nl     = {1'b0, new_bounds.low_bound};
   assign nm     = {1'b0, new_bounds.mid_bound};
   assign nn     = {1'b0, new_bounds.high_bound};
   assign gap    = {h, 1'b1};
   assign gap_lm = {1'b0, nm} - {1'b0, nl};
   assign gap_mn = {1'b0, nn} - {1'b0, nm};

   assign bounds_ok = (nl < nm) && (nm < nn) && (nn < amax) && (nl >= h) &&
                      ((amax - nn) >= h) && (gap_lm >= gap) && (gap_mn >= gap);

endmodule

// ----- hw/rtl/lswc_checker.sv -----
// ----------------------------------------------------------------------------
// lswc_checker
// Port-level checks of the leak sensor window classifier.
// ----------------------------------------------------------------------------
module lswc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [1:0]  rsp_sensor_state,
   input logic        rsp_state_changed,
   input logic [15:0] rsp_window_low,
   input logic [15:0] rsp_window_high,
   input logic        rsp_alert
);
   import lswc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sensor_state))
      else $error("stalled result dropped or changed");

   // No result right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Bad index gives an empty result
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_BAD_INDEX |->
         rsp_sensor_state == SNS_NOMINAL && !rsp_state_changed &&
         rsp_window_low == '0 && rsp_window_high == '0)
      else $error("bad index result not empty");

   // A sensor reported off nominal raises the alert
   a_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_OK && rsp_sensor_state != SNS_NOMINAL |->
         rsp_alert)
      else $error("alert low with a sensor off nominal");

   // Only accepted requests report a change
   a_changed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_state_changed |-> rsp_status == STS_OK)
      else $error("state change reported with error status");

endmodule

bind leak_sensor_window_classifier lswc_checker u_lswc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_sensor_state  (rsp_sensor_state),
   .rsp_state_changed (rsp_state_changed),
   .rsp_window_low    (rsp_window_low),
   .rsp_window_high   (rsp_window_high),
   .rsp_alert         (rsp_alert)
);

// ----- test/leak_sensor_window_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// leak_sensor_window_checker
// Watches the register port and both channels of the leak sensor window
// classifier. It keeps its own copy of the threshold table, the sensor states,
// the alert and the registers, predicts the result of every request
// transaction and compares each result transaction field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module leak_sensor_window_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lswc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lswc_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [3:0]                     req_sensor_index,
   input  logic [15:0]                    req_reading,
   input  logic [15:0]                    req_min_leak,
   input  logic [15:0]                    req_max_leak,
   input  logic [15:0]                    req_max_normal,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [1:0]                     rsp_status,
   input  logic [1:0]                     rsp_sensor_state,
   input  logic                           rsp_state_changed,
   input  logic [15:0]                    rsp_window_low,
   input  logic [15:0]                    rsp_window_high,
   input  logic                           rsp_alert,
   output int                             mismatch_count,
   output int                             outstanding
);
   import lswc_pkg::*;

   typedef struct {
      rsp_status_type   status;
      sensor_state_type state;
      logic             changed;
      logic [15:0]      win_lo;
      logic [15:0]      win_hi;
      logic             alert;
   } outcome_type;

   // Shadow copy of the classifier state
   logic [15:0]      lo_tbl    [SENSOR_COUNT];
   logic [15:0]      mid_tbl   [SENSOR_COUNT];
   logic [15:0]      hi_tbl    [SENSOR_COUNT];
   sensor_state_type state_tbl [SENSOR_COUNT];
   logic             alert_flag;
   logic [15:0]      cfg_hyst;
   logic [15:0]      cfg_max;
   logic [15:0]      cfg_min;

   outcome_type expected_q [$];
   outcome_type want;
   int          errors = 0;

   task automatic report_error(input string msg);
      errors++;
      $display("[%0t] checker: %s", $time, msg);
   endtask

   function automatic void update_alert();
      alert_flag = 1'b0;
      foreach (state_tbl[i]) begin
         if (state_tbl[i] != SNS_NOMINAL) begin
            alert_flag = 1'b1;
         end
      end
   endfunction

   // Apply one request to the shadow state and return the result it causes
   function automatic outcome_type classify_request(input logic [1:0] kind,
                                                    input logic [3:0] sidx,
                                                    input logic [15:0] rd,
                                                    input logic [15:0] nl,
                                                    input logic [15:0] nm,
                                                    input logic [15:0] nn);
      outcome_type      o;
      sensor_state_type prev;
      sensor_state_type next;
      int unsigned      h, l, m, n, amax, gap, wl, wh;
      int               slot;
      bit               ok;
      o.status  = STS_OK;
      o.state   = SNS_NOMINAL;
      o.changed = 1'b0;
      o.win_lo  = '0;
      o.win_hi  = '0;
      h    = cfg_hyst;
      amax = cfg_max;
      slot = sidx;
      if (kind == REQ_NONE) begin
         // ignored request: only the alert shows
      end else if (slot >= SENSOR_COUNT) begin
         o.status = STS_BAD_INDEX;
      end else begin
         case (kind)
            REQ_SAMPLE: begin
               prev = state_tbl[slot];
               if (rd < lo_tbl[slot]) begin
                  next = SNS_SHORT;
               end else if (rd < mid_tbl[slot]) begin
                  next = SNS_LEAK;
               end else if (rd < hi_tbl[slot]) begin
                  next = SNS_NOMINAL;
               end else begin
                  next = SNS_OPEN;
               end
               state_tbl[slot] = next;
               o.changed = (next != prev);
               o.state   = next;
               update_alert();
               // re-arm window around the new state, clamped to neighbors
               l = lo_tbl[slot];
               m = mid_tbl[slot];
               n = hi_tbl[slot];
               case (next)
                  SNS_SHORT: begin
                     wl = cfg_min;
                     wh = (l + h <= m) ? l + h : m;
                  end
                  SNS_LEAK: begin
                     wl = (l >= h) ? l - h : cfg_min;
                     wh = (m + h <= n) ? m + h : n;
                  end
                  SNS_NOMINAL: begin
                     wl = (m >= h && m - h >= l) ? m - h : l;
                     wh = (amax >= n && amax - n >= h) ? n + h : amax;
                  end
                  default: begin
                     wl = (n >= h && n - h >= m) ? n - h : m;
                     wh = amax;
                  end
               endcase
               o.win_lo = 16'(wl);
               o.win_hi = 16'(wh);
            end
            REQ_RESET: begin
               state_tbl[slot] = SNS_NOMINAL;
               update_alert();
            end
            default: begin
               l   = nl;
               m   = nm;
               n   = nn;
               gap = 2 * h + 1;
               ok  = (l < m) && (m < n) && (n < amax) && (l >= h) &&
                     (amax - n >= h) && (m - l >= gap) && (n - m >= gap);
               if (ok) begin
                  lo_tbl[slot]    = nl;
                  mid_tbl[slot]   = nm;
                  hi_tbl[slot]    = nn;
                  state_tbl[slot] = SNS_NOMINAL;
                  o.win_lo        = nm;
                  o.win_hi        = nn;
               end else begin
                  o.status = STS_BAD_BOUNDS;
                  o.state  = state_tbl[slot];
               end
            end
         endcase
      end
      o.alert = alert_flag;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (state_tbl[i]) begin
            lo_tbl[i]    = '0;
            mid_tbl[i]   = '0;
            hi_tbl[i]    = '0;
            state_tbl[i] = SNS_NOMINAL;
         end
         alert_flag = 1'b0;
         cfg_hyst   = HYST_RESET;
         cfg_max    = ADC_MAX_RESET;
         cfg_min    = ADC_MIN_RESET;
         expected_q.delete();
      end else begin
         // track register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_HYSTERESIS: cfg_hyst = csr_wdata;
               CSR_ADC_MAX:    cfg_max  = csr_wdata;
               CSR_ADC_MIN:    cfg_min  = csr_wdata;
               default: ;
            endcase
         end
         // predict each accepted request
         if (req_valid && req_ready) begin
            expected_q.push_back(classify_request(req_type, req_sensor_index,
                                                  req_reading, req_min_leak,
                                                  req_max_leak, req_max_normal));
         end
         // compare each accepted result with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_error("result transaction with no request outstanding");
            end else begin
               want = expected_q.pop_front();
               if (rsp_status !== want.status)
                  report_error($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
               if (rsp_sensor_state !== want.state)
                  report_error($sformatf("sensor_state %0d, expected %0d",
                                         rsp_sensor_state, want.state));
               if (rsp_state_changed !== want.changed)
                  report_error($sformatf("state_changed %0b, expected %0b",
                                         rsp_state_changed, want.changed));
               if (rsp_window_low !== want.win_lo)
                  report_error($sformatf("window_low %0d, expected %0d",
                                         rsp_window_low, want.win_lo));
               if (rsp_window_high !== want.win_hi)
                  report_error($sformatf("window_high %0d, expected %0d",
                                         rsp_window_high, want.win_hi));
               if (rsp_alert !== want.alert)
                  report_error($sformatf("alert %0b, expected %0b",
                                         rsp_alert, want.alert));
            end
         end
      end
      outstanding    <= expected_q.size();
      mismatch_count <= errors;
   end

endmodule

// ----- test/tb_leak_sensor_window_classifier.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_leak_sensor_window_classifier
// Drives the leak sensor window classifier through several register settings
// with a directed opening and random sample, reset and threshold-write
// requests, random idling on both channels and a long result stall. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_leak_sensor_window_classifier;
   import lswc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_type;
   logic [3:0]           req_sensor_index;
   logic [15:0]          req_reading;
   logic [15:0]          req_min_leak;
   logic [15:0]          req_max_leak;
   logic [15:0]          req_max_normal;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [1:0]           rsp_sensor_state;
   logic                 rsp_state_changed;
   logic [15:0]          rsp_window_low;
   logic [15:0]          rsp_window_high;
   logic                 rsp_alert;
   int                   mismatch_count;
   int                   outstanding;

   // Stimulus control shared by the sender and the receiver
   bit          no_idle     = 1'b0;
   int          hold_cycles = 0;
   int          cycle_count = 0;
   logic [15:0] cur_hyst    = HYST_RESET;
   logic [15:0] cur_max     = ADC_MAX_RESET;
   logic [15:0] aim_lo  [SENSOR_COUNT] = '{default: 16'd0};
   logic [15:0] aim_mid [SENSOR_COUNT] = '{default: 16'd0};
   logic [15:0] aim_hi  [SENSOR_COUNT] = '{default: 16'd0};

   leak_sensor_window_classifier uut (.*);
   leak_sensor_window_checker    checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input logic [3:0] sidx,
                               input logic [15:0] rd, input logic [15:0] nl,
                               input logic [15:0] nm, input logic [15:0] nn);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_sensor_index <= sidx;
      req_reading      <= rd;
      req_min_leak     <= nl;
      req_max_leak     <= nm;
      req_max_normal   <= nn;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers on consecutive edges
   task automatic set_registers(input logic [15:0] hyst, input logic [15:0] amax,
                                input logic [15:0] amin);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_HYSTERESIS;
      csr_wdata <= hyst;
      @(posedge clock);
      csr_index <= CSR_ADC_MAX;
      csr_wdata <= amax;
      @(posedge clock);
      csr_index <= CSR_ADC_MIN;
      csr_wdata <= amin;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_hyst = hyst;
      cur_max  = amax;
   endtask

   // Draw one request: mostly aimed samples and well-formed writes
   task automatic random_request(output bit counted);
      int          pick, lim, min_n, span, r1, r2, r3, off;
      logic [1:0]  kind;
      logic [3:0]  sidx;
      logic [15:0] rd, l, m, n, base;
      bit          aimed_write;
      sidx        = 4'($urandom_range(0, SENSOR_COUNT - 1));
      rd          = 16'($urandom);
      l           = 16'($urandom);
      m           = 16'($urandom);
      n           = 16'($urandom);
      kind        = REQ_SAMPLE;
      aimed_write = 1'b0;
      counted     = 1'b1;
      lim   = int'(cur_max) - int'(cur_hyst) - ((cur_hyst == 0) ? 1 : 0);
      min_n = 5 * int'(cur_hyst) + 2;
      pick  = $urandom_range(0, 99);
      if (pick < 45) begin
         // sample near a stored boundary, at a rail, or anywhere
         off = $urandom_range(0, 19);
         if (off == 0) begin
            rd = 16'h0000;
         end else if (off == 1) begin
            rd = 16'hFFFF;
         end else if (off < 17) begin
            case ($urandom_range(0, 2))
               0:       base = aim_lo[sidx];
               1:       base = aim_mid[sidx];
               default: base = aim_hi[sidx];
            endcase
            rd = 16'(int'(base) + int'($urandom_range(0, 3)) - 2);
         end
      end else if (pick < 55) begin
         kind = REQ_RESET;
      end else if (pick < 85) begin
         kind = REQ_WRITE;
         if (lim >= min_n) begin
            span = lim - min_n;
            r1 = $urandom_range(0, span);
            r2 = $urandom_range(0, span - r1);
            r3 = $urandom_range(0, span - r1 - r2);
            l = 16'(int'(cur_hyst) + r1);
            m = 16'(int'(l) + 2 * int'(cur_hyst) + 1 + r2);
            n = 16'(int'(m) + 2 * int'(cur_hyst) + 1 + r3);
            if (pick < 75) begin
               aimed_write = 1'b1;
            end else begin
               // break one rule just past its limit
               case ($urandom_range(0, 3))
                  0:       m = 16'(int'(l) + 2 * int'(cur_hyst));
                  1:       n = 16'(int'(m) + 2 * int'(cur_hyst));
                  2:       l = 16'(int'(cur_hyst) - 1);
                  default: n = 16'(int'(cur_max) - int'(cur_hyst) + 1);
               endcase
            end
         end
      end else if (pick < 90) begin
         kind = 2'($urandom_range(0, 2));
         sidx = 4'($urandom_range(SENSOR_COUNT, 15));
      end else if (pick < 93) begin
         kind    = REQ_NONE;
         counted = 1'b0;
      end else begin
         kind    = 2'($urandom);
         sidx    = 4'($urandom);
         counted = (kind != REQ_NONE);
      end
      if (aimed_write) begin
         aim_lo[sidx]  = l;
         aim_mid[sidx] = m;
         aim_hi[sidx]  = n;
      end
      send_request(kind, sidx, rd, l, m, n);
   endtask

   task automatic run_random(input int count);
      int done;
      bit counted;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
         random_request(counted);
         if (counted) done++;
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Request side and verdict
   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_HYSTERESIS;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_type         = REQ_SAMPLE;
      req_sensor_index = '0;
      req_reading      = '0;
      req_min_leak     = '0;
      req_max_leak     = '0;
      req_max_normal   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed opening at reset settings (hysteresis 16, range 0..4095)
      send_request(REQ_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(REQ_RESET, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(REQ_WRITE, 4'd0, 16'd0, 16'd100, 16'd400, 16'd1000);
      send_request(REQ_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'd99, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'd100, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'd399, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'd400, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'd999, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'd1000, 16'd0, 16'd0, 16'd0);
      send_request(REQ_SAMPLE, 4'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
      // each validity rule broken alone, but n at adc_max also breaks the margin
      send_request(REQ_WRITE, 4'd0, 16'd0, 16'd10, 16'd400, 16'd1000);
      send_request(REQ_WRITE, 4'd0, 16'd0, 16'd100, 16'd132, 16'd1000);
      send_request(REQ_WRITE, 4'd0, 16'd0, 16'd100, 16'd400, 16'd4095);
      send_request(REQ_WRITE, 4'd0, 16'd0, 16'd100, 16'd400, 16'd4080);
      send_request(REQ_WRITE, 4'd0, 16'd0, 16'd400, 16'd100, 16'd1000);
      // tightest valid thresholds
      send_request(REQ_WRITE, 4'd7, 16'd0, 16'd16, 16'd49, 16'd4079);
      send_request(REQ_SAMPLE, 4'd7, 16'd15, 16'd0, 16'd0, 16'd0);
      send_request(REQ_RESET, 4'd7, 16'd0, 16'd0, 16'd0, 16'd0);
      // index out of range and the ignored request type
      send_request(REQ_WRITE, 4'd15, 16'd0, 16'd100, 16'd400, 16'd1000);
      send_request(REQ_SAMPLE, 4'd8, 16'd500, 16'd0, 16'd0, 16'd0);
      send_request(REQ_RESET, 4'd9, 16'd0, 16'd0, 16'd0, 16'd0);
      send_request(REQ_NONE, 4'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain();

      // zero hysteresis, full range; open with a long result stall
      set_registers(16'd0, 16'hFFFF, 16'd0);
      hold_cycles = 200;
      no_idle     = 1'b1;
      run_random(40);
      no_idle     = 1'b0;
      run_random(310);
      drain();

      // reset-like settings with a raised bottom code
      set_registers(16'd16, 16'd4095, 16'd100);
      run_random(400);
      drain();

      // top extremes: no write can pass, windows saturate
      set_registers(16'hFFFF, 16'd0, 16'hFFFF);
      run_random(60);
      drain();

      // random settings, with a full pause in the middle
      set_registers(16'($urandom_range(0, 40)), 16'($urandom_range(1000, 65535)),
                    16'($urandom));
      run_random(150);
      drain();
      run_random(250);
      drain();

      set_registers(16'd3, 16'hFFFF, 16'hFFFF);
      run_random(300);
      drain();
      repeat (6) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/lswc_pkg.sv
hw/rtl/lswc_window.sv
hw/rtl/leak_sensor_window_classifier.sv
hw/rtl/lswc_checker.sv
test/leak_sensor_window_checker.sv
test/tb_leak_sensor_window_classifier.sv
